// ===== hdl/median_filter_3x3_core_macros.svh =====
// Assertion macros for the 3x3 median filter core.
// Expects signals named clk and rst in the scope of use.
`ifndef MEDIAN_FILTER_3X3_CORE_MACROS_SVH
`define MEDIAN_FILTER_3X3_CORE_MACROS_SVH

// condition and consequence in the same cycle
`define MF3_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence in the cycle after the condition
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mf3_pkg.sv =====
// Shared types and constants for the 3x3 median filter core.
// No dependencies; used by mf3_sort and median_filter_3x3_core.
`timescale 1ns / 1ps

package mf3_pkg;

  // fixed port widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int DIM_W   = 11;
  localparam int CFG_IDX_W = 4;

  // parameter defaults
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // frame size after reset
  localparam int RESET_DIM = 5;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 4'd0,
    REG_IMAGE_HEIGHT = 4'd1
  } mf3_reg_t;

  // 3x3 window and compare-exchange network for the fifth smallest
  localparam int WIN_SIZE   = 9;
  localparam int MEDIAN_IDX = 4;
  localparam int SORT_OPS   = 19;
  localparam int SORT_A [SORT_OPS] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0,
                                       5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int SORT_B [SORT_OPS] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3,
                                       8, 7, 6, 4, 5, 7, 2, 4, 2};

  // network split into pipeline groups of at most three compare levels
  localparam int SORT_GROUPS = 4;
  localparam int SORT_FIRST [SORT_GROUPS] = '{0, 6, 12, 16};
  localparam int SORT_LAST  [SORT_GROUPS] = '{5, 11, 15, 18};

  // sideband that travels with a result through the sort pipeline
  typedef struct packed {
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } mf3_tag_t;

endpackage

// ===== hdl/mf3_sort.sv =====
// Pipelined compare-exchange network picking the median of a 3x3 window.
// Depends on mf3_pkg (network tables, tag type).
`timescale 1ns / 1ps

module mf3_sort #(
  parameter int PW = mf3_pkg::PIX_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  mf3_pkg::mf3_tag_t    in_tag,
  input  logic [PW-1:0]        in_win [mf3_pkg::WIN_SIZE],
  output logic                 out_valid,
  output mf3_pkg::mf3_tag_t    out_tag,
  output logic [PW-1:0]        out_median
);

  import mf3_pkg::*;

  localparam int NREG = SORT_GROUPS - 1;

  // group inputs and outputs, registers between groups
  logic [PW-1:0] grp_in  [SORT_GROUPS][WIN_SIZE];
  logic [PW-1:0] grp_out [SORT_GROUPS][WIN_SIZE];
  logic [PW-1:0] stg_win [NREG][WIN_SIZE];
  logic          stg_valid [NREG];
  mf3_tag_t      stg_tag [NREG];

  genvar g;
  generate
    for (g = 0; g < SORT_GROUPS; g++) begin : gen_grp
      // group input: window for the first group, a stage register after that
      if (g == 0) begin : gen_head
        assign grp_in[g] = in_win;
      end else begin : gen_body
        assign grp_in[g] = stg_win[g-1];
      end

      // this group's share of the compare-exchange operations
      always_comb begin : net
        logic [PW-1:0] v [WIN_SIZE];
        logic [PW-1:0] t;
        v = grp_in[g];
        t = '0;
        for (int k = 0; k < SORT_OPS; k++) begin
          if (k >= SORT_FIRST[g] && k <= SORT_LAST[g]) begin
            if (v[SORT_A[k]] > v[SORT_B[k]]) begin
              t = v[SORT_A[k]];
              v[SORT_A[k]] = v[SORT_B[k]];
              v[SORT_B[k]] = t;
            end
          end
        end
        grp_out[g] = v;
      end
    end

    for (g = 0; g < NREG; g++) begin : gen_reg
      if (g == 0) begin : gen_first
        // first stage register, fed by the incoming window
        always_ff @(posedge clk) begin
          if (rst) begin
            stg_valid[g] <= 1'b0;
          end else if (en) begin
            stg_valid[g] <= in_valid;
          end
        end

        always_ff @(posedge clk) begin
          if (en) begin
            stg_tag[g] <= in_tag;
          end
        end
      end else begin : gen_next
        // later stage registers, fed by the stage before
        always_ff @(posedge clk) begin
          if (rst) begin
            stg_valid[g] <= 1'b0;
          end else if (en) begin
            stg_valid[g] <= stg_valid[g-1];
          end
        end

        always_ff @(posedge clk) begin
          if (en) begin
            stg_tag[g] <= stg_tag[g-1];
          end
        end
      end

      // partly sorted window, advanced by the shared enable
      always_ff @(posedge clk) begin
        if (en) begin
          stg_win[g] <= grp_out[g];
        end
      end
    end
  endgenerate

  // last group is left unregistered, the caller's output register follows
  assign out_valid  = stg_valid[NREG-1];
  assign out_tag    = stg_tag[NREG-1];
  assign out_median = grp_out[SORT_GROUPS-1][MEDIAN_IDX];

endmodule

// ===== hdl/median_filter_3x3_core.sv =====
// Streaming 3x3 median filter. Pixels enter one per clock while pix_stall is low, in raster
// order on the pix channel; every interior pixel gives one word on the res channel, in
// raster order, carrying the median of its nine neighbors, its row and column, and
// frame_last on the final interior pixel of the frame. Border pixels give no word. The
// sustained rate is one pixel per clock while res is not stalled: the two line stores are
// read once and written once per pixel, at different columns, and the compare network is
// split over pipeline stages. A result reaches res through the first-stage, window, sort
// stage and output registers. Writing image_width or image_height restarts the frame at
// row 0, column 0; values below 3 act as 3 and values above the maximum act as the
// maximum. Write configuration only while the block is idle.
// Depends on mf3_pkg, mf3_sort and median_filter_3x3_core_macros.svh.
`timescale 1ns / 1ps
`include "median_filter_3x3_core_macros.svh"

module median_filter_3x3_core #(
  parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // config write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mf3_pkg::DIM_W-1:0]    cfg_data,
  // pixel channel
  input  logic                         pix_valid,
  output logic                         pix_stall,
  input  logic [mf3_pkg::PIX_W-1:0]    pixel,
  // result channel
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [mf3_pkg::PIX_W-1:0]    median_value,
  output logic [mf3_pkg::COORD_W-1:0]  out_row,
  output logic [mf3_pkg::COORD_W-1:0]  out_col,
  output logic                         frame_last
);

  import mf3_pkg::*;

  localparam int PW    = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // last column or row index of a clamped frame dimension
  function automatic int dim_last(logic [DIM_W-1:0] v, int maxv);
    int d;
    d = int'(v);
    if (d < 3) return 2;
    if (d > maxv) return maxv - 1;
    return d - 1;
  endfunction

  localparam logic [COL_W-1:0] WLAST_RST = COL_W'(dim_last(DIM_W'(RESET_DIM), MAX_WIDTH));
  localparam logic [ROW_W-1:0] HLAST_RST = ROW_W'(dim_last(DIM_W'(RESET_DIM), MAX_HEIGHT));

  logic             advance;
  logic             pix_take;
  logic             cfg_take;
  logic             cfg_hit;
  logic [COL_W-1:0] wlast;
  logic [ROW_W-1:0] hlast;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;

  // line stores and their registered read data
  logic [PW-1:0] mem_above     [MAX_WIDTH];
  logic [PW-1:0] mem_two_above [MAX_WIDTH];
  logic [PW-1:0] rd_mid;
  logic [PW-1:0] rd_top;

  // first stage: accepted pixel with its position
  logic             s0_valid;
  logic             s0_emit;
  logic [PW-1:0]    s0_px;
  logic [COL_W-1:0] s0_col;
  mf3_tag_t         s0_tag;

  // window columns: 0..2 oldest column, 3..5 newer column (top, middle, bottom)
  logic [PW-1:0] wcol [6];

  // second stage: complete 3x3 window
  logic          s1_valid;
  mf3_tag_t      s1_tag;
  logic [PW-1:0] s1_win [WIN_SIZE];

  logic          srt_valid;
  mf3_tag_t      srt_tag;
  logic [PW-1:0] srt_median;

  // whole pipeline moves when the output register is free or being taken
  assign advance   = !res_valid || !res_stall;
  assign pix_stall = !advance;
  assign pix_take  = pix_valid && advance;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_take && (cfg_index == REG_IMAGE_WIDTH ||
                                  cfg_index == REG_IMAGE_HEIGHT);

  // frame dimensions, kept as the index of the last column and row
  always_ff @(posedge clk) begin
    if (rst) begin
      wlast <= WLAST_RST;
      hlast <= HLAST_RST;
    end else if (cfg_take) begin
      case (mf3_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  wlast <= COL_W'(dim_last(cfg_data, MAX_WIDTH));
        REG_IMAGE_HEIGHT: hlast <= ROW_W'(dim_last(cfg_data, MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // raster position of the next pixel
  always_comb begin
    col_next = col;
    row_next = row;
    if (cfg_hit) begin
      col_next = '0;
      row_next = '0;
    end else if (pix_take) begin
      if (col == wlast) begin
        col_next = '0;
        row_next = (row == hlast) ? '0 : row + 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // line store read at the incoming column, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      rd_mid <= mem_above[col];
      rd_top <= mem_two_above[col];
    end
  end

  // line store write-back when the pixel leaves the first stage
  always_ff @(posedge clk) begin
    if (advance && s0_valid) begin
      mem_above[s0_col]     <= s0_px;
      mem_two_above[s0_col] <= rd_mid;
    end
  end

  // first stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= pix_take;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      s0_px      <= pixel[PW-1:0];
      s0_col     <= col;
      s0_emit    <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
      s0_tag.last <= (row == hlast) && (col == wlast);
      s0_tag.row <= COORD_W'(row - 1'b1);
      s0_tag.col <= COORD_W'(col - 1'b1);
    end
  end

  // window shift: oldest column out, current column in
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        wcol[i] <= '0;
      end
    end else if (advance && s0_valid) begin
      wcol[0] <= wcol[3];
      wcol[1] <= wcol[4];
      wcol[2] <= wcol[5];
      wcol[3] <= rd_top;
      wcol[4] <= rd_mid;
      wcol[5] <= s0_px;
    end
  end

  // second stage: assemble the window for the sort network
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid && s0_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s0_valid) begin
      s1_tag    <= s0_tag;
      s1_win[0] <= wcol[0];
      s1_win[1] <= wcol[3];
      s1_win[2] <= rd_top;
      s1_win[3] <= wcol[1];
      s1_win[4] <= wcol[4];
      s1_win[5] <= rd_mid;
      s1_win[6] <= wcol[2];
      s1_win[7] <= wcol[5];
      s1_win[8] <= s0_px;
    end
  end

  mf3_sort #(
    .PW(PW)
  ) u_sort (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .in_valid   (s1_valid),
    .in_tag     (s1_tag),
    .in_win     (s1_win),
    .out_valid  (srt_valid),
    .out_tag    (srt_tag),
    .out_median (srt_median)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= srt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && srt_valid) begin
      median_value <= PIX_W'(srt_median);
      out_row      <= srt_tag.row;
      out_col      <= srt_tag.col;
      frame_last   <= srt_tag.last;
    end
  end

  // checks
  `MF3_ASSERT_SAME(a_no_store_collision, pix_take && s0_valid, col != s0_col, "line store read and write hit the same column")
  `MF3_ASSERT_SAME(a_position_in_frame, 1'b1, col <= wlast && row <= hlast, "raster position outside the frame")
  `MF3_ASSERT_SAME(a_stall_only_when_held, pix_stall, res_valid && res_stall, "pixel stalled with a free output register")
  `MF3_ASSERT_NEXT(a_frame_wrap, pix_take && !cfg_hit && col == wlast && row == hlast, col == '0 && row == '0, "counters did not wrap at frame end")

endmodule

// ===== tb/median_window_check.sv =====
`timescale 1ns / 1ps
// Checker for the 3x3 median filter: watches the config, pixel and result channels,
// predicts every result word and compares it field by field with what comes out.
// Depends on mf3_pkg; instantiated by tb_top beside median_filter_3x3_core.

module median_window_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mf3_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          pix_valid,
  input  logic                          pix_stall,
  input  logic [mf3_pkg::PIX_W-1:0]     pixel,
  input  logic                          res_valid,
  input  logic                          res_stall,
  input  logic [mf3_pkg::PIX_W-1:0]     median_value,
  input  logic [mf3_pkg::COORD_W-1:0]   out_row,
  input  logic [mf3_pkg::COORD_W-1:0]   out_col,
  input  logic                          frame_last,
  input  logic                          run_over,
  output int                            error_count,
  output int                            pending,
  output int                            pixels_seen,
  output int                            results_seen,
  output int                            settings_seen
);

  import mf3_pkg::*;

  localparam int MIN_DIM     = 3;

  // one result word as it leaves the block
  typedef struct packed {
    logic [PIX_W-1:0]   median;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } median_word_t;

  median_word_t expected_words[$];

  // predicted block state
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [PIX_W-1:0] row_minus1 [0:MAX_WIDTH_DEF-1];
  logic [PIX_W-1:0] row_minus2 [0:MAX_WIDTH_DEF-1];
  logic [PIX_W-1:0] col_prev1 [0:2];
  logic [PIX_W-1:0] col_prev2 [0:2];
  int col_pos;
  int row_pos;
  logic leftover_checked;

  task automatic flag_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // register value as the block uses it
  function automatic int dim_in_use(input logic [DIM_W-1:0] v, input int limit);
    if (int'(v) < MIN_DIM) return MIN_DIM;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // value with at most four smaller and at least five not larger
  function automatic logic [PIX_W-1:0] fifth_smallest(input logic [WIN_SIZE*PIX_W-1:0] vals);
    int below;
    int not_above;
    logic [PIX_W-1:0] a;
    fifth_smallest = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      a = vals[i*PIX_W +: PIX_W];
      below = 0;
      not_above = 0;
      for (int j = 0; j < WIN_SIZE; j++) begin
        if (vals[j*PIX_W +: PIX_W] < a) below++;
        if (vals[j*PIX_W +: PIX_W] <= a) not_above++;
      end
      if (below <= MEDIAN_IDX && not_above > MEDIAN_IDX) fifth_smallest = a;
    end
  endfunction

  always @(posedge clk) begin : predict_and_compare
    median_word_t got;
    median_word_t want;
    logic [PIX_W-1:0] above2;
    logic [PIX_W-1:0] above1;
    logic [WIN_SIZE*PIX_W-1:0] nine;
    int w;
    int h;
    int c;
    int r;
    if (rst) begin
      width_reg = DIM_W'(RESET_DIM);
      height_reg = DIM_W'(RESET_DIM);
      col_pos = 0;
      row_pos = 0;
      for (int k = 0; k < 3; k++) begin
        col_prev1[k] = '0;
        col_prev2[k] = '0;
      end
      for (int k = 0; k < MAX_WIDTH_DEF; k++) begin
        row_minus1[k] = '0;
        row_minus2[k] = '0;
      end
      expected_words.delete();
      error_count = 0;
      pixels_seen = 0;
      results_seen = 0;
      settings_seen = 0;
      leftover_checked = 1'b0;
    end else begin
      // compare an outgoing word with the oldest prediction
      if (res_valid && !res_stall) begin
        results_seen++;
        got = {median_value, out_row, out_col, frame_last};
        if (expected_words.size() == 0) begin
          flag_mismatch($sformatf("word with no prediction: row %0d col %0d median %0d",
                                  got.row, got.col, got.median));
        end else begin
          want = expected_words.pop_front();
          if (got.median !== want.median)
            flag_mismatch($sformatf("median at row %0d col %0d: got %0d want %0d",
                                    want.row, want.col, got.median, want.median));
          if (got.row !== want.row)
            flag_mismatch($sformatf("out_row: got %0d want %0d", got.row, want.row));
          if (got.col !== want.col)
            flag_mismatch($sformatf("out_col at row %0d: got %0d want %0d",
                                    want.row, got.col, want.col));
          if (got.last !== want.last)
            flag_mismatch($sformatf("frame_last at row %0d col %0d: got %0d want %0d",
                                    want.row, want.col, got.last, want.last));
        end
      end

      // register write restarts the frame; spare indexes change nothing
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          width_reg = cfg_data;
          col_pos = 0;
          row_pos = 0;
          settings_seen++;
        end else if (cfg_index == REG_IMAGE_HEIGHT) begin
          height_reg = cfg_data;
          col_pos = 0;
          row_pos = 0;
          settings_seen++;
        end
      end

      // accepted pixel: predict, then advance window, line stores and counters
      if (pix_valid && !pix_stall) begin
        pixels_seen++;
        w = dim_in_use(width_reg, MAX_WIDTH_DEF);
        h = dim_in_use(height_reg, MAX_HEIGHT_DEF);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        above2 = row_minus2[c];
        above1 = row_minus1[c];
        if (r >= 2 && c >= 2) begin
          nine = {col_prev2[0], col_prev1[0], above2,
                  col_prev2[1], col_prev1[1], above1,
                  col_prev2[2], col_prev1[2], pixel};
          want.median = fifth_smallest(nine);
          want.row = COORD_W'(r - 1);
          want.col = COORD_W'(c - 1);
          want.last = (r == h - 1) && (c == w - 1);
          expected_words.push_back(want);
        end
        for (int k = 0; k < 3; k++) col_prev2[k] = col_prev1[k];
        col_prev1[0] = above2;
        col_prev1[1] = above1;
        col_prev1[2] = pixel;
        row_minus2[c] = above1;
        row_minus1[c] = pixel;
        if (c + 1 >= w) begin
          col_pos = 0;
          row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
          col_pos = c + 1;
          row_pos = r;
        end
      end

      // predictions still waiting once the run is over
      if (run_over && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_words.size() != 0)
          flag_mismatch($sformatf("%0d predicted words never came out",
                                  expected_words.size()));
      end
    end
    pending <= expected_words.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top level of the 3x3 median filter testbench: clock, reset, pixel and config
// stimulus, receiver stalls and the final verdict.
// Depends on mf3_pkg, median_filter_3x3_core and median_window_check.

module tb_top;
  import mf3_pkg::*;

  localparam int RANDOM_PIXELS = 1060;
  localparam int TALL_PIXELS   = 60;
  localparam int RUN_LIMIT_NS  = 2_000_000;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RESET_CYCLES  = 11;
  localparam int MIN_DIM       = 3;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = CFG_IDX_W'(REG_IMAGE_HEIGHT + 1);
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = '1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {PIX_ANY, PIX_FEW_LEVELS, PIX_EXTREMES} pixel_mix_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  logic [PIX_W-1:0]     pixel = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [PIX_W-1:0]     median_value;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic                 frame_last;
  logic                 run_over = 1'b0;

  int gap_pct = 0;
  int stall_pct = 0;
  int error_count;
  int pending;
  int pixels_seen;
  int results_seen;
  int settings_seen;

  always #2 clk = ~clk;

  median_filter_3x3_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pixel        (pixel),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .median_value (median_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .frame_last   (frame_last)
  );

  median_window_check u_median_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .pixel         (pixel),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .median_value  (median_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .frame_last    (frame_last),
    .run_over      (run_over),
    .error_count   (error_count),
    .pending       (pending),
    .pixels_seen   (pixels_seen),
    .results_seen  (results_seen),
    .settings_seen (settings_seen)
  );

  // receiver stalls at random while a stalling phase is on
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // hard stop if the run hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        gap_pct = 56;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct <= 56;
      end
      IDLE_BOTH: begin
        gap_pct = 7;
        stall_pct <= 7;
      end
      default: begin
        gap_pct = 0;
        stall_pct <= 0;
      end
    endcase
  endtask

  // one pixel word, with random sender gaps ahead of it
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pixel <= value;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input pixel_mix_t mix);
    case (mix)
      PIX_FEW_LEVELS: return PIX_W'($urandom_range(3) << (PIX_W - 2));
      PIX_EXTREMES:   return ($urandom_range(1) != 0) ? {PIX_W{1'b1}} : '0;
      default:        return PIX_W'($urandom_range((1 << PIX_W) - 1));
    endcase
  endfunction

  task automatic send_run(input int count, input pixel_mix_t mix);
    for (int i = 0; i < count; i++) send_pixel(pick_pixel(mix));
  endtask

  // valid stays high across back-to-back writes; end_writes lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic end_writes;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every predicted word is out, then let the pipeline settle
  task automatic wait_idle;
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int seg;
    int w_val;
    int h_val;
    int cur_w;
    int cur_h;
    int count;
    int random_sent;
    int waited;
    logic wrote;
    pixel_mix_t mix;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size 5x5: two rows plus three pixels give the first interior word
    set_idling(IDLE_NONE);
    for (int k = 0; k < 13; k++) begin
      send_pixel((k % 3 == 0) ? {PIX_W{1'b1}} : PIX_W'(k * 19));
    end
    wait_idle();

    // height above the maximum acts as the maximum, so rows run on past small sizes
    write_reg(REG_IMAGE_WIDTH, DIM_W'(MIN_DIM));
    write_reg(REG_IMAGE_HEIGHT, '1);
    end_writes();
    send_run(TALL_PIXELS, PIX_ANY);
    wait_idle();

    // sizes below the minimum act as 3x3, and the write restarts the frame
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(MIN_DIM - 1));
    end_writes();
    for (int k = 0; k < 9; k++) begin
      send_pixel((k == 4) ? PIX_W'(1 << (PIX_W - 1)) : ((k % 2 != 0) ? {PIX_W{1'b1}} : '0));
    end

    // a spare register index mid-frame must leave the frame position alone
    send_run(4, PIX_EXTREMES);
    wait_idle();
    write_reg(SPARE_IDX_HI, '1);
    end_writes();
    send_run(5, PIX_ANY);

    // random frames, mostly whole ones, under rotating idling patterns
    cur_w = MIN_DIM;
    cur_h = MIN_DIM;
    random_sent = 0;
    seg = 0;
    while (random_sent < RANDOM_PIXELS) begin
      wait_idle();
      set_idling(idle_mode_t'(seg % 4));
      wrote = 1'b0;
      if ($urandom_range(99) < 80) begin
        w_val = ($urandom_range(9) == 0) ? $urandom_range(MIN_DIM - 1) : $urandom_range(MIN_DIM, 12);
        h_val = ($urandom_range(9) == 0) ? $urandom_range(MIN_DIM - 1) : $urandom_range(MIN_DIM, 9);
        if ($urandom_range(3) != 0) begin
          write_reg(REG_IMAGE_WIDTH, DIM_W'(w_val));
          cur_w = (w_val < MIN_DIM) ? MIN_DIM : w_val;
          wrote = 1'b1;
        end
        if (!wrote || $urandom_range(3) != 0) begin
          write_reg(REG_IMAGE_HEIGHT, DIM_W'(h_val));
          cur_h = (h_val < MIN_DIM) ? MIN_DIM : h_val;
          wrote = 1'b1;
        end
      end
      if ($urandom_range(9) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)),
                  DIM_W'($urandom_range((1 << DIM_W) - 1)));
        wrote = 1'b1;
      end
      if (wrote) end_writes();
      if ($urandom_range(3) != 0) begin
        count = cur_w * cur_h * $urandom_range(1, 3);
      end else begin
        count = $urandom_range(1, 2 * cur_w * cur_h);
      end
      if (count > RANDOM_PIXELS - random_sent) count = RANDOM_PIXELS - random_sent;
      mix = pixel_mix_t'($urandom_range(2));
      send_run(count, mix);
      random_sent += count;
      seg++;
    end

    // drain
    pix_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    run_over <= 1'b1;
    repeat (3) @(posedge clk);

    $display("Streamed %0d pixels through %0d register writes and checked %0d median words,",
             pixels_seen, settings_seen, results_seen);
    $display("frames up to 12 wide, a clamped tall frame, sender gaps and receiver stalls.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mf3_pkg.sv
hdl/mf3_sort.sv
hdl/median_filter_3x3_core.sv
tb/median_window_check.sv
tb/tb_top.sv
